### hw/rtl/ifsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ifsb_pkg;

	localparam int unsigned FRAME_W   = 16;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned MPS_W     = 10;
	localparam int unsigned IVL_W     = 8;
	localparam int unsigned OFF_W     = 12;
	localparam int unsigned WIDX_W    = 4;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MPS      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 8'd1;

	localparam logic [MPS_W-1:0] MPS_RESET      = 10'd1023;
	localparam logic [IVL_W-1:0] INTERVAL_RESET = 8'd1;

	localparam logic [WIDX_W-1:0] WORD_CTRL = 4'd0;
	localparam logic [WIDX_W-1:0] WORD_PAGE = 4'd1;
	localparam logic [WIDX_W-1:0] WORD_END  = 4'd2;
	localparam logic [WIDX_W-1:0] WORD_PKT0 = 4'd3;
	localparam logic [WIDX_W-1:0] WORD_LAST = 4'd10;

	localparam logic [3:0] CC_NOT_ACCESSED = 4'hE;

	typedef struct packed {
		logic [MPS_W-1:0] plen;
		logic [LEN_W-1:0] rem_next;
		logic [OFF_W-1:0] endoff_next;
		logic [OFF_W-1:0] last_off;
		logic             rem_zero;
	} seg_out_t;

endpackage

`default_nettype wire

### hw/rtl/ifsb_frame_sel.sv
`timescale 1ns / 1ps
`default_nettype none

module ifsb_frame_sel (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          commit,
	input  wire logic [ifsb_pkg::FRAME_W-1:0]  requested_frame,
	input  wire logic [ifsb_pkg::FRAME_W-1:0]  frame_count,
	input  wire logic [ifsb_pkg::IVL_W-1:0]    interval,
	output logic      [ifsb_pkg::FRAME_W-1:0]  frame
);

	logic [ifsb_pkg::FRAME_W-1:0] next_frame_q;
	logic [ifsb_pkg::IVL_W+2:0]   lead;
	logic [ifsb_pkg::FRAME_W-1:0] cand;
	logic [ifsb_pkg::FRAME_W-1:0] diff;
	logic [ifsb_pkg::FRAME_W:0]   span;
	logic                         cand_ok;

	// interval is already forced nonzero, so lead = interval*8 >= 8
	assign lead    = {interval, 3'b000};
	assign cand    = (requested_frame == '0) ? next_frame_q : requested_frame;
	assign diff    = cand - frame_count;
	assign span    = {1'b0, diff} + (ifsb_pkg::FRAME_W+1)'(lead);
	assign cand_ok = (cand != '0) && (cand > frame_count) && !span[ifsb_pkg::FRAME_W];
	assign frame   = cand_ok ? cand : frame_count + ifsb_pkg::FRAME_W'(lead);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_frame_q <= '0;
		end else if (commit) begin
			next_frame_q <= frame + ifsb_pkg::FRAME_W'(interval);
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ifsb_seg_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module ifsb_seg_unit (
	input  wire logic [ifsb_pkg::LEN_W-1:0] rem,
	input  wire logic [ifsb_pkg::MPS_W-1:0] mps,
	input  wire logic [ifsb_pkg::OFF_W-1:0] endoff,
	output ifsb_pkg::seg_out_t              seg
);

	always_comb begin
		seg.plen        = (rem > ifsb_pkg::LEN_W'(mps)) ? mps : rem[ifsb_pkg::MPS_W-1:0];
		seg.rem_next    = rem - ifsb_pkg::LEN_W'(seg.plen);
		seg.endoff_next = endoff + ifsb_pkg::OFF_W'(seg.plen);
		seg.last_off    = seg.endoff_next - ifsb_pkg::OFF_W'(1);
		seg.rem_zero    = (seg.rem_next == '0);
	end

endmodule

`default_nettype wire

### hw/rtl/iso_frame_schedule_and_td_build.sv
`timescale 1ns / 1ps
`default_nettype none
// Order: a taken request passes a schedule step, a counting pass over its P packets
// (P = packets, 1..MAX_PACKETS) and the emit step; a rejected request goes from the
// schedule step to its single result. The next request is taken only after the last
// result; the shared packet subtract unit runs a counting pass and then an offset pass.
// Reset: next frame clears to 0, max packet size to 1023, interval to 1; no clearing pass.

module iso_frame_schedule_and_td_build #(
	parameter int unsigned MAX_PACKETS = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [ifsb_pkg::FRAME_W-1:0]     requested_frame,
	input  wire logic [ifsb_pkg::LEN_W-1:0]       length,
	input  wire logic [ifsb_pkg::ADDR_W-1:0]      buffer_address,
	input  wire logic [ifsb_pkg::FRAME_W-1:0]     frame_count,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [ifsb_pkg::WIDX_W-1:0]      word_index,
	output logic      [ifsb_pkg::ADDR_W-1:0]      word_value,
	output logic      [ifsb_pkg::FRAME_W-1:0]     scheduled_frame,
	output logic                                  rejected,
	output logic                                  last,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [ifsb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ifsb_pkg::CFG_DAT_W-1:0]   cfg_data
);

	localparam int unsigned PKT_W = $clog2(MAX_PACKETS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCHED = 2'd1;
	localparam logic [1:0] ST_COUNT = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;

	logic [ifsb_pkg::MPS_W-1:0]   mps_q;
	logic [ifsb_pkg::IVL_W-1:0]   interval_q;
	logic [ifsb_pkg::MPS_W-1:0]   mps_eff;
	logic [ifsb_pkg::IVL_W-1:0]   interval_eff;

	logic [ifsb_pkg::FRAME_W-1:0] req_q;
	logic [ifsb_pkg::LEN_W-1:0]   len_q;
	logic [ifsb_pkg::ADDR_W-1:0]  addr_q;
	logic [ifsb_pkg::FRAME_W-1:0] now_q;
	logic [ifsb_pkg::FRAME_W-1:0] frame_q;
	logic                         rej_q;
	logic [ifsb_pkg::LEN_W-1:0]   rem_q;
	logic [ifsb_pkg::OFF_W-1:0]   endoff_q;
	logic [PKT_W-1:0]             cnt_q;
	logic [ifsb_pkg::WIDX_W-1:0]  widx_q;

	logic                         out_valid_q;
	logic [ifsb_pkg::WIDX_W-1:0]  word_index_q;
	logic [ifsb_pkg::ADDR_W-1:0]  word_value_q;
	logic [ifsb_pkg::FRAME_W-1:0] sfr_q;
	logic                         rejected_q;
	logic                         last_q;

	logic [ifsb_pkg::FRAME_W-1:0] frame_sel;
	ifsb_pkg::seg_out_t           seg;
	logic                         in_take;
	logic                         out_load;
	logic                         pkt_slot;
	logic [ifsb_pkg::WIDX_W-1:0]  slot;
	logic [ifsb_pkg::ADDR_W-1:0]  word_next;

	assign mps_eff      = (mps_q == '0) ? ifsb_pkg::MPS_W'(1) : mps_q;
	assign interval_eff = (interval_q == '0) ? ifsb_pkg::IVL_W'(1) : interval_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mps_q      <= ifsb_pkg::MPS_RESET;
			interval_q <= ifsb_pkg::INTERVAL_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == ifsb_pkg::CFG_MPS) begin
				mps_q <= cfg_data[ifsb_pkg::MPS_W-1:0];
			end else if (cfg_index == ifsb_pkg::CFG_INTERVAL) begin
				interval_q <= cfg_data[ifsb_pkg::IVL_W-1:0];
			end
		end
	end

	ifsb_frame_sel u_frame_sel (
		.clk             (clk),
		.arst_n          (arst_n),
		.commit          (state_q == ST_SCHED),
		.requested_frame (req_q),
		.frame_count     (now_q),
		.interval        (interval_eff),
		.frame           (frame_sel)
	);

	ifsb_seg_unit u_seg_unit (
		.rem    (rem_q),
		.mps    (mps_eff),
		.endoff (endoff_q),
		.seg    (seg)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	assign slot     = widx_q - ifsb_pkg::WORD_PKT0;
	assign pkt_slot = (slot < ifsb_pkg::WIDX_W'(cnt_q));

	always_comb begin
		case (widx_q)
			ifsb_pkg::WORD_CTRL: word_next = {ifsb_pkg::CC_NOT_ACCESSED, 1'b0,
				3'(cnt_q - PKT_W'(1)), 8'h00, frame_q};
			ifsb_pkg::WORD_PAGE: word_next = {addr_q[ifsb_pkg::ADDR_W-1:ifsb_pkg::OFF_W],
				ifsb_pkg::OFF_W'(0)};
			ifsb_pkg::WORD_END:  word_next = addr_q + ifsb_pkg::ADDR_W'(len_q)
				- ifsb_pkg::ADDR_W'(1);
			default:             word_next = {16'h0000, ifsb_pkg::CC_NOT_ACCESSED,
				pkt_slot ? seg.last_off : ifsb_pkg::OFF_W'(0)};
		endcase
		if (rej_q) begin
			word_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			widx_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_SCHED;
					end
				end
				ST_SCHED: begin
					cnt_q  <= '0;
					widx_q <= ifsb_pkg::WORD_CTRL;
					state_q <= (len_q == '0) ? ST_EMIT : ST_COUNT;
				end
				ST_COUNT: begin
					cnt_q <= cnt_q + PKT_W'(1);
					if (seg.rem_zero || (cnt_q + PKT_W'(1) == PKT_W'(MAX_PACKETS))) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						widx_q <= widx_q + ifsb_pkg::WIDX_W'(1);
						if (rej_q || widx_q == ifsb_pkg::WORD_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_q  <= requested_frame;
			len_q  <= length;
			addr_q <= buffer_address;
			now_q  <= frame_count;
		end
		if (state_q == ST_SCHED) begin
			frame_q  <= frame_sel;
			rej_q    <= (len_q == '0);
			rem_q    <= len_q;
		end
		if (state_q == ST_COUNT) begin
			if (seg.rem_zero || (cnt_q + PKT_W'(1) == PKT_W'(MAX_PACKETS))) begin
				rem_q    <= len_q;
				endoff_q <= addr_q[ifsb_pkg::OFF_W-1:0];
			end else begin
				rem_q <= seg.rem_next;
			end
		end
		if (out_load && widx_q >= ifsb_pkg::WORD_PKT0 && pkt_slot) begin
			rem_q    <= seg.rem_next;
			endoff_q <= seg.endoff_next;
		end
		if (out_load) begin
			word_index_q <= rej_q ? ifsb_pkg::WORD_CTRL : widx_q;
			word_value_q <= word_next;
			sfr_q        <= frame_q;
			rejected_q   <= rej_q;
			last_q       <= rej_q || (widx_q == ifsb_pkg::WORD_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign word_index      = word_index_q;
	assign word_value      = word_value_q;
	assign scheduled_frame = sfr_q;
	assign rejected        = rejected_q;
	assign last            = last_q;

`ifndef SYNTH
	a_take_to_sched: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == ST_SCHED))
		else $error("request taken without entering schedule step");

	a_count_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COUNT) |-> (rem_q != '0))
		else $error("packet count pass running on empty buffer");

	a_pkt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (cnt_q <= PKT_W'(MAX_PACKETS)))
		else $error("packet count above limit");

	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rejected_q) |-> (last_q && word_index_q == ifsb_pkg::WORD_CTRL
			&& word_value_q == '0))
		else $error("rejected result malformed");

	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q && !rejected_q) |-> (word_index_q == ifsb_pkg::WORD_LAST))
		else $error("last flag on wrong descriptor word");
`endif

endmodule

`default_nettype wire
